>>> rtl/csla_pkg.sv
package csla_pkg;

  localparam int DATA_W    = 16;
  localparam int WEIGHT_W  = 9;
  localparam int FRAC_W    = 8;
  localparam int BLEND_W   = DATA_W + WEIGHT_W;
  localparam int REG_IDX_W = 2;

  localparam int AVG_DEPTH = 6;
  localparam int IDX_W     = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int SUM_W     = DATA_W + $clog2(AVG_DEPTH);

  // floor(s / AVG_DEPTH) == (s * RCP_MULT) >> RCP_SHIFT for every s below 2**SUM_W
  localparam int RCP_SHIFT = SUM_W + $clog2(AVG_DEPTH);
  localparam int RCP_W     = SUM_W + 1;
  localparam int PROD_W    = SUM_W + RCP_W;
  localparam logic [RCP_W-1:0] RCP_MULT =
    RCP_W'(((2 ** RCP_SHIFT) + AVG_DEPTH - 1) / AVG_DEPTH);

  localparam logic [WEIGHT_W-1:0] Q8_ONE = WEIGHT_W'(256);

  localparam logic [DATA_W-1:0]   UPPER_RST  = DATA_W'(3000);
  localparam logic [DATA_W-1:0]   LOWER_RST  = DATA_W'(850);
  localparam logic [DATA_W-1:0]   STEP_RST   = DATA_W'(100);
  localparam logic [WEIGHT_W-1:0] WEIGHT_RST = WEIGHT_W'(218);
  localparam logic [DATA_W-1:0]   PREV_RST   = DATA_W'(1000);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_UPPER  = 2'd0,
    REG_LOWER  = 2'd1,
    REG_STEP   = 2'd2,
    REG_WEIGHT = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [DATA_W-1:0]   upper_limit;
    logic [DATA_W-1:0]   lower_limit;
    logic [DATA_W-1:0]   max_step;
    logic [WEIGHT_W-1:0] retain_weight;
  } cfg_t;

endpackage

>>> rtl/clamp_slew_lag_average_filter.sv
// Speed/period smoother: each sample word is clamped to [lower_limit, upper_limit],
// replaced by the last accepted sample when it jumps by more than max_step, passed
// through a Q8 first-order lag weighted by retain_weight, and averaged over the
// last six lag outputs (the history starts at zero after reset, lag and spike
// references start at 1000). One smoothed word comes out per sample word. A new
// sample is taken every cycle unless in_stall holds it back; a result passes
// through three registered stages: the clamp/spike/lag recurrence, the ring-sum
// update and the reciprocal multiply that divides by the depth. Stall from the output
// holds all three stages back. Configuration writes take effect on the next sample.
module clamp_slew_lag_average_filter (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [csla_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [csla_pkg::DATA_W-1:0]     cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [csla_pkg::DATA_W-1:0]     sample,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [csla_pkg::DATA_W-1:0]     smoothed
);

  csla_pkg::cfg_t               cfg;
  logic                         lag_valid;
  logic                         lag_stall;
  logic [csla_pkg::DATA_W-1:0]  lag;
  logic                         sum_valid;
  logic                         sum_stall;
  logic [csla_pkg::SUM_W-1:0]   ring_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.upper_limit   <= csla_pkg::UPPER_RST;
      cfg.lower_limit   <= csla_pkg::LOWER_RST;
      cfg.max_step      <= csla_pkg::STEP_RST;
      cfg.retain_weight <= csla_pkg::WEIGHT_RST;
    end else if (cfg_write) begin
      case (csla_pkg::reg_idx_t'(cfg_index))
        csla_pkg::REG_UPPER: begin
          cfg.upper_limit <= cfg_data;
        end
        csla_pkg::REG_LOWER: begin
          cfg.lower_limit <= cfg_data;
        end
        csla_pkg::REG_STEP: begin
          cfg.max_step <= cfg_data;
        end
        csla_pkg::REG_WEIGHT: begin
          cfg.retain_weight <= cfg_data[csla_pkg::WEIGHT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  csla_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample    (sample),
    .lag_valid (lag_valid),
    .lag_stall (lag_stall),
    .lag       (lag)
  );

  csla_ring u_ring (
    .clk       (clk),
    .rst       (rst),
    .lag_valid (lag_valid),
    .lag_stall (lag_stall),
    .lag       (lag),
    .sum_valid (sum_valid),
    .sum_stall (sum_stall),
    .ring_sum  (ring_sum)
  );

  csla_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .sum_valid (sum_valid),
    .sum_stall (sum_stall),
    .ring_sum  (ring_sum),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .smoothed  (smoothed)
  );

`ifndef SYNTHESIS
  a_stall_needs_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && lag_valid && sum_valid))
    else $error("input stalled with a bubble in the pipe");

  a_stall_from_out: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_stall)
    else $error("input stalled while output drains");
`endif

endmodule

>>> rtl/csla_front.sv
module csla_front (
  input  logic                         clk,
  input  logic                         rst,
  input  csla_pkg::cfg_t               cfg,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [csla_pkg::DATA_W-1:0]  sample,
  output logic                         lag_valid,
  input  logic                         lag_stall,
  output logic [csla_pkg::DATA_W-1:0]  lag
);

  logic                            accept;
  logic [csla_pkg::DATA_W-1:0]     clamped;
  logic [csla_pkg::DATA_W-1:0]     diff;
  logic                            spike;
  logic [csla_pkg::DATA_W-1:0]     x_sel;
  logic [csla_pkg::WEIGHT_W-1:0]   w;
  logic [csla_pkg::WEIGHT_W-1:0]   w_inv;
  logic [csla_pkg::BLEND_W-1:0]    blend;
  logic [csla_pkg::DATA_W-1:0]     accepted_prev;
  logic [csla_pkg::DATA_W-1:0]     lag_prev;

  assign in_stall = lag_valid & lag_stall;
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    if (sample > cfg.upper_limit) begin
      clamped = cfg.upper_limit;
    end else if (sample < cfg.lower_limit) begin
      clamped = cfg.lower_limit;
    end else begin
      clamped = sample;
    end
    diff  = (clamped >= accepted_prev) ? (clamped - accepted_prev)
                                       : (accepted_prev - clamped);
    spike = diff > cfg.max_step;
    x_sel = spike ? accepted_prev : clamped;
    // weights past unity saturate, which freezes the lag output
    w     = (cfg.retain_weight > csla_pkg::Q8_ONE) ? csla_pkg::Q8_ONE : cfg.retain_weight;
    w_inv = csla_pkg::Q8_ONE - w;
    blend = csla_pkg::BLEND_W'(w) * csla_pkg::BLEND_W'(lag_prev)
          + csla_pkg::BLEND_W'(w_inv) * csla_pkg::BLEND_W'(x_sel);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accepted_prev <= csla_pkg::PREV_RST;
      lag_prev      <= csla_pkg::PREV_RST;
      lag_valid     <= 1'b0;
    end else begin
      if (accept) begin
        lag_prev <= blend[csla_pkg::FRAC_W +: csla_pkg::DATA_W];
        if (!spike) begin
          accepted_prev <= clamped;
        end
      end
      if (accept) begin
        lag_valid <= 1'b1;
      end else if (!lag_stall) begin
        lag_valid <= 1'b0;
      end
    end
  end

  // the lag state register doubles as this stage's output word
  assign lag = lag_prev;

endmodule

>>> rtl/csla_ring.sv
module csla_ring (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         lag_valid,
  output logic                         lag_stall,
  input  logic [csla_pkg::DATA_W-1:0]  lag,
  output logic                         sum_valid,
  input  logic                         sum_stall,
  output logic [csla_pkg::SUM_W-1:0]   ring_sum
);

  logic                         accept;
  logic [csla_pkg::DATA_W-1:0]  ring [csla_pkg::AVG_DEPTH];
  logic [csla_pkg::IDX_W-1:0]   ring_idx;
  logic [csla_pkg::IDX_W-1:0]   ring_idx_next;
  logic [csla_pkg::SUM_W-1:0]   ring_sum_next;

  assign lag_stall = sum_valid & sum_stall;
  assign accept    = lag_valid & ~lag_stall;

  always_comb begin
    ring_sum_next = ring_sum - csla_pkg::SUM_W'(ring[ring_idx]) + csla_pkg::SUM_W'(lag);
    if (ring_idx == csla_pkg::IDX_W'(csla_pkg::AVG_DEPTH - 1)) begin
      ring_idx_next = '0;
    end else begin
      ring_idx_next = ring_idx + csla_pkg::IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < csla_pkg::AVG_DEPTH; i++) begin
        ring[i] <= '0;
      end
      ring_idx  <= '0;
      ring_sum  <= '0;
      sum_valid <= 1'b0;
    end else begin
      if (accept) begin
        ring[ring_idx] <= lag;
        ring_idx       <= ring_idx_next;
        ring_sum       <= ring_sum_next;
        sum_valid      <= 1'b1;
      end else if (!sum_stall) begin
        sum_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    ring_idx <= csla_pkg::IDX_W'(csla_pkg::AVG_DEPTH - 1))
    else $error("ring index past depth");

  a_sum_range: assert property (@(posedge clk) disable iff (rst)
    ring_sum <= csla_pkg::SUM_W'(csla_pkg::AVG_DEPTH * 65535))
    else $error("ring sum out of range");
`endif

endmodule

>>> rtl/csla_scale.sv
module csla_scale (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         sum_valid,
  output logic                         sum_stall,
  input  logic [csla_pkg::SUM_W-1:0]   ring_sum,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [csla_pkg::DATA_W-1:0]  smoothed
);

  logic                          accept;
  logic [csla_pkg::PROD_W-1:0]   prod;

  assign sum_stall = out_valid & out_stall;
  assign accept    = sum_valid & ~sum_stall;

  // divide by the ring depth through a reciprocal multiply
  assign prod = csla_pkg::PROD_W'(ring_sum) * csla_pkg::PROD_W'(csla_pkg::RCP_MULT);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      smoothed <= prod[csla_pkg::RCP_SHIFT +: csla_pkg::DATA_W];
    end
  end

endmodule
